// File: hw/rtl/ddo_pkg.sv
// Shared types, constants and the arctangent table of the wheel odometry block.
`timescale 1ns / 1ps
`default_nettype none

package ddo_pkg;

	// Configuration register reset values
	localparam logic [23:0] DISTANCE_PER_COUNT_RESET  = 24'd14641;
	localparam logic [23:0] INVERSE_TRACK_WIDTH_RESET = 24'd370260;

	// Register indexes on the configuration port
	localparam logic REG_DISTANCE_PER_COUNT  = 1'b0;
	localparam logic REG_INVERSE_TRACK_WIDTH = 1'b1;

	// Angle constants in Q16.16
	localparam logic [18:0] TWO_PI_Q16  = 19'd411775;
	localparam logic [18:0] PI_Q16      = 19'd205887;
	localparam logic [18:0] HALF_PI_Q16 = 19'd102944;

	// CORDIC start vector: limit gain in Q2.30
	localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

	localparam int CORDIC_STEPS_DEFAULT = 16;
	localparam int ATAN_ENTRIES         = 24;

	// Angle reduction: four remainder bits a cycle over a 60-bit magnitude
	localparam int MOD_BITS_PER_CYCLE = 4;
	localparam int MOD_DIGITS         = 15;
	localparam int MOD_DIG_W          = $clog2(MOD_DIGITS);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_L,
		ST_MUL_R,
		ST_SUM,
		ST_ABS,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_MAG,
		ST_MOD,
		ST_FOLD,
		ST_ROT,
		ST_MUL_C,
		ST_MUL_S,
		ST_POS_Y,
		ST_OUT
	} ddo_state_t;

	// Arctangent of 2^-i in Q2.30
	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0:    v = 30'd843314857;
			5'd1:    v = 30'd497837830;
			5'd2:    v = 30'd263043837;
			5'd3:    v = 30'd133525159;
			5'd4:    v = 30'd67021687;
			5'd5:    v = 30'd33543516;
			5'd6:    v = 30'd16775851;
			5'd7:    v = 30'd8388437;
			5'd8:    v = 30'd4194283;
			5'd9:    v = 30'd2097149;
			5'd10:   v = 30'd1048576;
			5'd11:   v = 30'd524288;
			5'd12:   v = 30'd262144;
			5'd13:   v = 30'd131072;
			5'd14:   v = 30'd65536;
			5'd15:   v = 30'd32768;
			5'd16:   v = 30'd16384;
			5'd17:   v = 30'd8192;
			5'd18:   v = 30'd4096;
			5'd19:   v = 30'd2048;
			5'd20:   v = 30'd1024;
			5'd21:   v = 30'd512;
			5'd22:   v = 30'd256;
			5'd23:   v = 30'd128;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/differential_drive_odometry.sv
// Differential-drive wheel odometry: sequencer, shared multiplier, reduction and CORDIC.
`timescale 1ns / 1ps
`default_nettype none

// Wheel odometry for a differential-drive base. Each input transaction carries the absolute
// left and right encoder counts (op = 0) or a clear command (op = 1); each gives exactly one
// result transaction with x, y, mean travel and unwrapped heading, all signed Q16.16 and
// saturating. A measure runs from one accepted transaction to the next through the two wheel
// products, their sum and difference and the two heading partial products through the one
// shared 33x32 multiplier, the remainder steps for the heading modulo 2*pi, the fold of the
// angle, one CORDIC rotation a cycle, the two position products and their sums, the load of
// the output register and the return to idle to accept. A clear goes from idle straight to
// the output load. Either waits there while a still untaken earlier result holds the output
// register. in_ready is high only while the sequencer is idle; a finished result waits in
// the output register while the next transaction is accepted. Configuration is an APB-style
// port with distance_per_count at address 0 and inverse_track_width at address 4.
module differential_drive_odometry #(
	parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEFAULT
) (
	input  wire                clk,
	input  wire                arst_n,
	// input channel
	input  wire                in_valid,
	output logic               in_ready,
	input  wire                op,
	input  wire signed  [31:0] left_count,
	input  wire signed  [31:0] right_count,
	// result channel
	output logic               out_valid,
	input  wire                out_ready,
	output logic signed [31:0] pose_x,
	output logic signed [31:0] pose_y,
	output logic signed [31:0] travel,
	output logic signed [31:0] heading,
	// configuration port
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire         [2:0]  paddr,
	input  wire         [31:0] pwdata,
	output logic        [31:0] prdata,
	output logic               pready
);

	localparam int STEP_W = $clog2(CORDIC_STEPS);
	localparam int MOD_DIG_W_L = ddo_pkg::MOD_DIG_W;
	localparam logic signed [33:0] Z_LIMIT = $signed({1'b0, ddo_pkg::HALF_PI_Q16, 14'b0});

	ddo_pkg::ddo_state_t state_q, state_d;

	// configuration
	logic [23:0] dpc_q;
	logic [23:0] itw_q;

	// kept state
	logic signed [31:0] pos_x_q, pos_y_q, prev_q;

	// working registers
	logic signed [31:0] left_q, right_q;
	logic signed [64:0] p_q;
	logic signed [55:0] wl_q;
	logic signed [56:0] diff_q;
	logic        [56:0] m_q;
	logic               neg_q;
	logic        [31:0] lo_q;
	logic        [59:0] sh_q;
	logic        [18:0] rem_q;
	logic [MOD_DIG_W_L-1:0] dig_q;
	logic signed [31:0] trav_q, head_q;
	logic signed [31:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic [STEP_W-1:0]  cnt_q;
	logic signed [32:0] d_q;

	// output register
	logic               out_valid_q;
	logic signed [31:0] pose_x_q, pose_y_q, travel_q, heading_q;

	// multiplier operands
	logic signed [32:0] mul_a;
	logic signed [31:0] mul_b;

	// combinational datapath values
	logic signed [55:0] wr_w;
	logic signed [56:0] sum_w;
	logic        [56:0] mag_w;
	logic signed [31:0] head_w;
	logic        [18:0] rem_w;
	logic        [18:0] r0_w;
	logic signed [20:0] r1_w, r2_w;
	logic               flip_w;
	logic signed [33:0] z_init_w;
	logic signed [31:0] xs_w, ys_w;
	logic signed [33:0] atan_w;
	logic signed [35:0] pos_sum_w;

	logic cfg_wr;
	logic in_acc;
	logic out_load;

	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		logic signed [31:0] r;
		if (v > 48'sh0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < 48'shFFFF_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	assign in_ready  = (state_q == ddo_pkg::ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_load  = (state_q == ddo_pkg::ST_OUT) && (!out_valid_q || out_ready);
	assign cfg_wr    = psel && penable && pwrite;
	assign pready    = 1'b1;
	assign out_valid = out_valid_q;
	assign pose_x    = pose_x_q;
	assign pose_y    = pose_y_q;
	assign travel    = travel_q;
	assign heading   = heading_q;

	// Hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpc_q <= ddo_pkg::DISTANCE_PER_COUNT_RESET;
			itw_q <= ddo_pkg::INVERSE_TRACK_WIDTH_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				ddo_pkg::REG_DISTANCE_PER_COUNT:  dpc_q <= pwdata[23:0];
				ddo_pkg::REG_INVERSE_TRACK_WIDTH: itw_q <= pwdata[23:0];
			endcase
		end
	end

	// Return register contents on read
	always_comb begin
		unique case (paddr[2])
			ddo_pkg::REG_DISTANCE_PER_COUNT:  prdata = {8'b0, dpc_q};
			ddo_pkg::REG_INVERSE_TRACK_WIDTH: prdata = {8'b0, itw_q};
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ddo_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequence the steps of one transaction
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ddo_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = op ? ddo_pkg::ST_OUT : ddo_pkg::ST_MUL_L;
				end
			end
			ddo_pkg::ST_MUL_L:  state_d = ddo_pkg::ST_MUL_R;
			ddo_pkg::ST_MUL_R:  state_d = ddo_pkg::ST_SUM;
			ddo_pkg::ST_SUM:    state_d = ddo_pkg::ST_ABS;
			ddo_pkg::ST_ABS:    state_d = ddo_pkg::ST_MUL_LO;
			ddo_pkg::ST_MUL_LO: state_d = ddo_pkg::ST_MUL_HI;
			ddo_pkg::ST_MUL_HI: state_d = ddo_pkg::ST_MAG;
			ddo_pkg::ST_MAG:    state_d = ddo_pkg::ST_MOD;
			ddo_pkg::ST_MOD: begin
				if (dig_q == MOD_DIG_W_L'(ddo_pkg::MOD_DIGITS - 1)) begin
					state_d = ddo_pkg::ST_FOLD;
				end
			end
			ddo_pkg::ST_FOLD:   state_d = ddo_pkg::ST_ROT;
			ddo_pkg::ST_ROT: begin
				if (cnt_q == STEP_W'(CORDIC_STEPS - 1)) begin
					state_d = ddo_pkg::ST_MUL_C;
				end
			end
			ddo_pkg::ST_MUL_C:  state_d = ddo_pkg::ST_MUL_S;
			ddo_pkg::ST_MUL_S:  state_d = ddo_pkg::ST_POS_Y;
			ddo_pkg::ST_POS_Y:  state_d = ddo_pkg::ST_OUT;
			ddo_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = ddo_pkg::ST_IDLE;
				end
			end
			default:            state_d = ddo_pkg::ST_IDLE;
		endcase
	end

	// Select operands of the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ddo_pkg::ST_MUL_L: begin
				mul_a = $signed({left_q[31], left_q});
				mul_b = $signed({8'b0, dpc_q});
			end
			ddo_pkg::ST_MUL_R: begin
				mul_a = $signed({right_q[31], right_q});
				mul_b = $signed({8'b0, dpc_q});
			end
			ddo_pkg::ST_MUL_LO: begin
				mul_a = $signed({1'b0, m_q[31:0]});
				mul_b = $signed({8'b0, itw_q});
			end
			ddo_pkg::ST_MUL_HI: begin
				mul_a = $signed({8'b0, m_q[56:32]});
				mul_b = $signed({8'b0, itw_q});
			end
			ddo_pkg::ST_MUL_C: begin
				mul_a = d_q;
				mul_b = x_q;
			end
			ddo_pkg::ST_MUL_S: begin
				mul_a = d_q;
				mul_b = y_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Travel sum, heading magnitude and its saturated form
	always_comb begin
		wr_w  = p_q[55:0];
		sum_w = $signed({wl_q[55], wl_q}) + $signed({wr_w[55], wr_w});
		mag_w = {p_q[48:0], 8'b0} + {25'b0, lo_q};
		if (neg_q) begin
			if (mag_w > 57'h0_8000_0000) begin
				head_w = 32'sh8000_0000;
			end else begin
				head_w = $signed(32'(32'd0 - mag_w[31:0]));
			end
		end else begin
			if (mag_w > 57'h0_7FFF_FFFF) begin
				head_w = 32'sh7FFF_FFFF;
			end else begin
				head_w = $signed(mag_w[31:0]);
			end
		end
	end

	// Four restoring remainder steps against 2*pi
	always_comb begin
		logic [19:0] t;
		logic [18:0] rv;
		rv = rem_q;
		for (int k = 0; k < ddo_pkg::MOD_BITS_PER_CYCLE; k++) begin
			t = {rv, sh_q[59 - k]};
			if (t >= {1'b0, ddo_pkg::TWO_PI_Q16}) begin
				t = t - {1'b0, ddo_pkg::TWO_PI_Q16};
			end
			rv = t[18:0];
		end
		rem_w = rv;
	end

	// Map the remainder into -pi to pi and fold into the right half-plane
	always_comb begin
		if (neg_q && (rem_q != '0)) begin
			r0_w = ddo_pkg::TWO_PI_Q16 - rem_q;
		end else begin
			r0_w = rem_q;
		end
		if (r0_w >= ddo_pkg::PI_Q16) begin
			r1_w = $signed({2'b0, r0_w}) - $signed({2'b0, ddo_pkg::TWO_PI_Q16});
		end else begin
			r1_w = $signed({2'b0, r0_w});
		end
		flip_w = 1'b0;
		r2_w   = r1_w;
		if (r1_w > $signed({2'b0, ddo_pkg::HALF_PI_Q16})) begin
			r2_w   = r1_w - $signed({2'b0, ddo_pkg::PI_Q16});
			flip_w = 1'b1;
		end else if (r1_w < -$signed({2'b0, ddo_pkg::HALF_PI_Q16})) begin
			r2_w   = r1_w + $signed({2'b0, ddo_pkg::PI_Q16});
			flip_w = 1'b1;
		end
		z_init_w = $signed({{2{r2_w[17]}}, r2_w[17:0], 14'b0});
	end

	// One CORDIC rotation: floor shifts and arctangent of this step
	always_comb begin
		xs_w   = x_q >>> cnt_q;
		ys_w   = y_q >>> cnt_q;
		atan_w = $signed({4'b0, ddo_pkg::atan_q30(5'(cnt_q))});
	end

	// Position accumulate from the registered product
	always_comb begin
		if (state_q == ddo_pkg::ST_MUL_S) begin
			pos_sum_w = $signed({{4{pos_x_q[31]}}, pos_x_q}) + $signed({p_q[64], p_q[64:30]});
		end else begin
			pos_sum_w = $signed({{4{pos_y_q[31]}}, pos_y_q}) + $signed({p_q[64], p_q[64:30]});
		end
	end

	// Advance the working registers
	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
		case (state_q)
			ddo_pkg::ST_IDLE: begin
				left_q  <= left_count;
				right_q <= right_count;
				if (in_valid && op) begin
					trav_q <= '0;
					head_q <= '0;
				end
			end
			ddo_pkg::ST_MUL_R: begin
				wl_q <= p_q[55:0];
			end
			ddo_pkg::ST_SUM: begin
				trav_q <= sat32(sum_w[56:9]);
				diff_q <= $signed({wr_w[55], wr_w}) - $signed({wl_q[55], wl_q});
			end
			ddo_pkg::ST_ABS: begin
				neg_q <= diff_q[56];
				m_q   <= diff_q[56] ? 57'(-diff_q) : 57'(diff_q);
			end
			ddo_pkg::ST_MUL_HI: begin
				lo_q <= p_q[55:24];
			end
			ddo_pkg::ST_MAG: begin
				sh_q   <= {3'b0, mag_w};
				rem_q  <= '0;
				dig_q  <= '0;
				head_q <= head_w;
			end
			ddo_pkg::ST_MOD: begin
				rem_q <= rem_w;
				sh_q  <= {sh_q[55:0], 4'b0};
				dig_q <= dig_q + 1'b1;
			end
			ddo_pkg::ST_FOLD: begin
				x_q   <= ddo_pkg::CORDIC_GAIN_Q30;
				y_q   <= '0;
				z_q   <= z_init_w;
				cnt_q <= '0;
				// negate the step instead of cosine and sine
				if (flip_w) begin
					d_q <= $signed({prev_q[31], prev_q}) - $signed({trav_q[31], trav_q});
				end else begin
					d_q <= $signed({trav_q[31], trav_q}) - $signed({prev_q[31], prev_q});
				end
			end
			ddo_pkg::ST_ROT: begin
				if (!z_q[33]) begin
					x_q <= x_q - ys_w;
					y_q <= y_q + xs_w;
					z_q <= z_q - atan_w;
				end else begin
					x_q <= x_q + ys_w;
					y_q <= y_q - xs_w;
					z_q <= z_q + atan_w;
				end
				cnt_q <= cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Update the kept pose; clear drops it to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			prev_q  <= '0;
		end else if (in_acc && op) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			prev_q  <= '0;
		end else if (state_q == ddo_pkg::ST_MUL_S) begin
			pos_x_q <= sat32(48'(pos_sum_w));
		end else if (state_q == ddo_pkg::ST_POS_Y) begin
			pos_y_q <= sat32(48'(pos_sum_w));
			prev_q  <= trav_q;
		end
	end

	// Output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			pose_x_q  <= pos_x_q;
			pose_y_q  <= pos_y_q;
			travel_q  <= trav_q;
			heading_q <= head_q;
		end
	end

	// A clear leaves a zero pose and goes straight to the result
	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && op) |=> (pos_x_q == '0 && pos_y_q == '0 && prev_q == '0 &&
			state_q == ddo_pkg::ST_OUT))
		else $error("clear did not zero the pose");

	// The running remainder stays below 2*pi
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ddo_pkg::ST_MOD) |-> (rem_q < ddo_pkg::TWO_PI_Q16))
		else $error("angle remainder out of range");

	// The first rotation starts within a quarter turn
	a_z_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ddo_pkg::ST_ROT && cnt_q == '0) |-> (z_q <= Z_LIMIT && z_q >= -Z_LIMIT))
		else $error("reduced angle outside a quarter turn");

	// A waiting result is not overwritten by the next transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ddo_pkg::ST_OUT && out_valid_q && !out_ready) |=>
			(out_valid_q && $stable(pose_x_q) && $stable(heading_q) &&
			state_q == ddo_pkg::ST_OUT))
		else $error("pending result overwritten");

endmodule

`default_nettype wire
